FILE: rtl/ocd_pkg.sv
`default_nettype none

package ocd_pkg;

  localparam int DIGITS = 4;
  localparam int DIGIT_W = 4;
  localparam int COUNT_W = 6;
  localparam int TIME_W = 7;
  localparam int MODE_W = 3;
  localparam int KEY_W = 8;

  localparam logic [KEY_W-1:0] KEY_START  = 8'h43;
  localparam logic [KEY_W-1:0] KEY_CANCEL = 8'h3D;
  localparam logic [KEY_W-1:0] KEY_ZERO   = 8'h30;
  localparam logic [KEY_W-1:0] KEY_NINE   = 8'h39;

  localparam logic [COUNT_W-1:0] MAX_FIELD = 6'd59;

  localparam logic [MODE_W-1:0] CODE_ENTRY = 3'd0;
  localparam logic [MODE_W-1:0] CODE_ARMED = 3'd1;
  localparam logic [MODE_W-1:0] CODE_RUN   = 3'd2;
  localparam logic [MODE_W-1:0] CODE_HOLD  = 3'd3;
  localparam logic [MODE_W-1:0] CODE_PAUSE = 3'd4;

  typedef enum logic [4:0] {
    MODE_ENTRY = 5'b00001,
    MODE_ARMED = 5'b00010,
    MODE_RUN   = 5'b00100,
    MODE_HOLD  = 5'b01000,
    MODE_PAUSE = 5'b10000
  } mode_t;

  typedef logic [DIGIT_W-1:0] digit_t;

  // Two decimal digits to a binary value, tens digit first.
  function automatic logic [7:0] two_digit(input digit_t hi, input digit_t lo);
    logic [7:0] hi8;
    hi8 = {4'b0000, hi};
    return (hi8 << 3) + (hi8 << 1) + {4'b0000, lo};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/oven_countdown_controller.sv
// Channel  Direction  tdata (low bit up)                                  tuser
// in_      slave      key_code[7:0], door_closed[8], zero pad to 16 bits   func
// out_     master     mode[2:0], minutes_left[9:3], seconds_left[16:10],    none
//                     beep[17], done_res[18], invalid_time[19], pad to 24
//
// One request is taken every clock cycle while the result register can drain; a
// result passes through the input register and then the result register.
// The mode, digit and count registers update as a request moves from the input
// register into the result register, so consecutive requests see each other.
// Reset clears all control state to entry mode with a zero time.
// A stalled result holds in the result register; the input register then
// keeps its request and in_tready drops until the result drains.
`default_nettype none

module oven_countdown_controller #(
  parameter int Digits = ocd_pkg::DIGITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,  // key_code[7:0], door_closed[8]
  input  wire logic [0:0]  in_tuser,  // func[0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata  // mode, minutes, seconds, beep, done, invalid
);

  localparam int PressW = (Digits > 1) ? $clog2(Digits) : 1;

  logic                               s1_valid_r;
  logic                               func_r;
  logic [ocd_pkg::KEY_W-1:0]          key_r;
  logic                               closed_r;
  logic                               advance;
  logic                               s1_fire;

  ocd_pkg::mode_t                     mode_r, mode_nxt;
  ocd_pkg::digit_t                    digit_r [Digits];
  ocd_pkg::digit_t                    digit_nxt [Digits];
  logic [PressW-1:0]                  press_r, press_nxt;
  logic [ocd_pkg::COUNT_W-1:0]        min_r, min_nxt;
  logic [ocd_pkg::COUNT_W-1:0]        sec_r, sec_nxt;
  logic                               beep_nxt, done_nxt, inval_nxt;
  logic [7:0]                         ent_min, ent_sec;
  logic [7:0]                         new_min, new_sec;
  logic [ocd_pkg::MODE_W-1:0]         code_nxt;
  logic [ocd_pkg::TIME_W-1:0]         show_min_nxt, show_sec_nxt;
  logic                               is_key, key_start, key_cancel, key_digit;
  logic                               any_digit;

  logic                               out_valid_r;
  logic [ocd_pkg::MODE_W-1:0]         out_mode_r;
  logic [ocd_pkg::TIME_W-1:0]         out_min_r, out_sec_r;
  logic                               out_beep_r, out_done_r, out_inval_r;

  assign advance   = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      func_r   <= in_tuser[0];
      key_r    <= in_tdata[7:0];
      closed_r <= in_tdata[8];
    end
  end

  assign is_key     = !func_r;
  assign key_start  = is_key && (key_r == ocd_pkg::KEY_START);
  assign key_cancel = is_key && (key_r == ocd_pkg::KEY_CANCEL);
  assign ent_min    = ocd_pkg::two_digit(digit_r[Digits-1], digit_r[Digits-2]);
  assign ent_sec    = ocd_pkg::two_digit(digit_r[1], digit_r[0]);

  always_comb begin
    mode_nxt  = mode_r;
    press_nxt = press_r;
    min_nxt   = min_r;
    sec_nxt   = sec_r;
    beep_nxt  = 1'b0;
    done_nxt  = 1'b0;
    inval_nxt = 1'b0;
    key_digit = key_r inside {[ocd_pkg::KEY_ZERO:ocd_pkg::KEY_NINE]};
    any_digit = 1'b0;
    for (int i = 0; i < Digits; i++) begin
      digit_nxt[i] = digit_r[i];
    end

    case (mode_r)
      ocd_pkg::MODE_ENTRY: begin
        if (is_key) begin
          if (key_digit) begin
            for (int i = Digits - 1; i > 0; i--) begin
              digit_nxt[i] = digit_r[i-1];
            end
            digit_nxt[0] = key_r[ocd_pkg::DIGIT_W-1:0];
          end
          for (int i = 0; i < Digits; i++) begin
            any_digit = any_digit | (|digit_nxt[i]);
          end
          if (press_r == PressW'(Digits - 1)) begin
            press_nxt = '0;
            if (any_digit) begin
              mode_nxt = ocd_pkg::MODE_ARMED;
            end else begin
              for (int i = 0; i < Digits; i++) begin
                digit_nxt[i] = '0;
              end
            end
          end else begin
            press_nxt = press_r + PressW'(1);
          end
        end
      end
      ocd_pkg::MODE_ARMED: begin
        if (key_start) begin
          if (!closed_r) begin
            beep_nxt = 1'b1;
          end else if (ent_min > 8'(ocd_pkg::MAX_FIELD) ||
                       ent_sec > 8'(ocd_pkg::MAX_FIELD)) begin
            inval_nxt = 1'b1;
            beep_nxt  = 1'b1;
            mode_nxt  = ocd_pkg::MODE_ENTRY;
            press_nxt = '0;
            for (int i = 0; i < Digits; i++) begin
              digit_nxt[i] = '0;
            end
          end else begin
            min_nxt  = ent_min[ocd_pkg::COUNT_W-1:0];
            sec_nxt  = ent_sec[ocd_pkg::COUNT_W-1:0];
            mode_nxt = ocd_pkg::MODE_RUN;
          end
        end else if (key_cancel) begin
          mode_nxt  = ocd_pkg::MODE_ENTRY;
          press_nxt = '0;
          for (int i = 0; i < Digits; i++) begin
            digit_nxt[i] = '0;
          end
        end
      end
      ocd_pkg::MODE_RUN: begin
        if (!closed_r) begin
          mode_nxt = ocd_pkg::MODE_HOLD;
          beep_nxt = 1'b1;
        end else if (func_r) begin
          if (sec_r == '0) begin
            if (min_r != '0) begin
              sec_nxt = ocd_pkg::MAX_FIELD;
              min_nxt = min_r - ocd_pkg::COUNT_W'(1);
            end
          end else begin
            sec_nxt = sec_r - ocd_pkg::COUNT_W'(1);
          end
          if (min_nxt == '0 && sec_nxt == '0) begin
            done_nxt  = 1'b1;
            mode_nxt  = ocd_pkg::MODE_ENTRY;
            press_nxt = '0;
            for (int i = 0; i < Digits; i++) begin
              digit_nxt[i] = '0;
            end
          end
        end else if (key_r == ocd_pkg::KEY_START) begin
          mode_nxt = ocd_pkg::MODE_PAUSE;
        end
      end
      ocd_pkg::MODE_HOLD: begin
        if (key_start) begin
          if (closed_r) begin
            mode_nxt = ocd_pkg::MODE_RUN;
          end else begin
            beep_nxt = 1'b1;
          end
        end
      end
      ocd_pkg::MODE_PAUSE: begin
        if (key_start) begin
          if (closed_r) begin
            mode_nxt = ocd_pkg::MODE_RUN;
          end else begin
            mode_nxt = ocd_pkg::MODE_HOLD;
            beep_nxt = 1'b1;
          end
        end else if (key_cancel) begin
          mode_nxt  = ocd_pkg::MODE_ENTRY;
          press_nxt = '0;
          for (int i = 0; i < Digits; i++) begin
            digit_nxt[i] = '0;
          end
        end
      end
      default: begin
        mode_nxt  = ocd_pkg::MODE_ENTRY;
        press_nxt = '0;
        for (int i = 0; i < Digits; i++) begin
          digit_nxt[i] = '0;
        end
      end
    endcase
  end

  assign new_min = ocd_pkg::two_digit(digit_nxt[Digits-1], digit_nxt[Digits-2]);
  assign new_sec = ocd_pkg::two_digit(digit_nxt[1], digit_nxt[0]);

  always_comb begin
    show_min_nxt = {1'b0, min_nxt};
    show_sec_nxt = {1'b0, sec_nxt};
    case (mode_nxt)
      ocd_pkg::MODE_ENTRY: begin
        code_nxt     = ocd_pkg::CODE_ENTRY;
        show_min_nxt = new_min[ocd_pkg::TIME_W-1:0];
        show_sec_nxt = new_sec[ocd_pkg::TIME_W-1:0];
      end
      ocd_pkg::MODE_ARMED: begin
        code_nxt     = ocd_pkg::CODE_ARMED;
        show_min_nxt = new_min[ocd_pkg::TIME_W-1:0];
        show_sec_nxt = new_sec[ocd_pkg::TIME_W-1:0];
      end
      ocd_pkg::MODE_RUN:   code_nxt = ocd_pkg::CODE_RUN;
      ocd_pkg::MODE_HOLD:  code_nxt = ocd_pkg::CODE_HOLD;
      ocd_pkg::MODE_PAUSE: code_nxt = ocd_pkg::CODE_PAUSE;
      default:             code_nxt = ocd_pkg::CODE_ENTRY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ocd_pkg::MODE_ENTRY;
      press_r <= '0;
      min_r   <= '0;
      sec_r   <= '0;
      for (int i = 0; i < Digits; i++) begin
        digit_r[i] <= '0;
      end
    end else if (s1_fire) begin
      mode_r  <= mode_nxt;
      press_r <= press_nxt;
      min_r   <= min_nxt;
      sec_r   <= sec_nxt;
      for (int i = 0; i < Digits; i++) begin
        digit_r[i] <= digit_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_mode_r  <= code_nxt;
      out_min_r   <= show_min_nxt;
      out_sec_r   <= show_sec_nxt;
      out_beep_r  <= beep_nxt;
      out_done_r  <= done_nxt;
      out_inval_r <= inval_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_inval_r, out_done_r, out_beep_r,
                       out_sec_r, out_min_r, out_mode_r};

  // A finished countdown always lands in entry mode showing a zero time.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |->
      out_mode_r == ocd_pkg::CODE_ENTRY && out_min_r == '0 && out_sec_r == '0)
    else $error("done result not in entry mode with zero time");

  // A rejected time beeps and clears the entry.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_inval_r |->
      out_beep_r && out_mode_r == ocd_pkg::CODE_ENTRY && out_min_r == '0 && out_sec_r == '0)
    else $error("invalid time result without beep or cleared entry");

  // The running count never shows more than 59 in either field.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_mode_r == ocd_pkg::CODE_RUN || out_mode_r == ocd_pkg::CODE_HOLD ||
                    out_mode_r == ocd_pkg::CODE_PAUSE) |->
      out_min_r <= 7'(ocd_pkg::MAX_FIELD) && out_sec_r <= 7'(ocd_pkg::MAX_FIELD))
    else $error("count out of range outside entry");

  // Control state only changes when a request passes into the result register.
  assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> $stable(mode_r) && $stable(press_r) && $stable(min_r) && $stable(sec_r))
    else $error("state changed without a request");

  // The press counter is back at zero whenever the block is not in entry mode.
  assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != ocd_pkg::MODE_ENTRY |-> press_r == '0)
    else $error("press count left over outside entry mode");

endmodule

`default_nettype wire

FILE: tb/tb_oven_countdown_controller.sv
`timescale 1ns / 1ps

module tb_oven_countdown_controller;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_REQS = 700;

  typedef struct packed {
    logic                      func;
    logic [ocd_pkg::KEY_W-1:0] key;
    logic                      door;
    logic                      drain;
  } oven_req_t;

  typedef struct packed {
    logic [ocd_pkg::MODE_W-1:0] mode;
    logic [ocd_pkg::TIME_W-1:0] mins;
    logic [ocd_pkg::TIME_W-1:0] secs;
    logic                       beep;
    logic                       done;
    logic                       bad;
  } oven_disp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  oven_req_t  req_pending[$];
  oven_disp_t disp_expected[$];
  oven_req_t  on_bus;
  logic       mark_drain = 1'b0;

  logic [ocd_pkg::MODE_W-1:0]  st_mode;
  logic [ocd_pkg::DIGIT_W-1:0] st_dig[ocd_pkg::DIGITS];
  logic [2:0]                  st_presses;
  logic [ocd_pkg::TIME_W-1:0]  st_min;
  logic [ocd_pkg::TIME_W-1:0]  st_sec;

  int in_gap = 0;
  int out_stall = 0;
  bit in_steady = 1'b0;
  bit out_steady = 1'b0;
  int n_req = 0;
  int n_res = 0;
  int n_done = 0;
  int n_bad = 0;
  int n_beep = 0;
  int n_err = 0;
  int cycle_cnt = 0;

  oven_countdown_controller i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int entry_mins();
    return int'(st_dig[3]) * 10 + int'(st_dig[2]);
  endfunction

  function automatic int entry_secs();
    return int'(st_dig[1]) * 10 + int'(st_dig[0]);
  endfunction

  function automatic void clear_entry();
    for (int i = 0; i < ocd_pkg::DIGITS; i++) st_dig[i] = '0;
    st_presses = '0;
    st_mode = ocd_pkg::CODE_ENTRY;
  endfunction

  task automatic ref_init();
    clear_entry();
    st_min = '0;
    st_sec = '0;
  endtask

  function automatic oven_disp_t oven_step(oven_req_t r);
    oven_disp_t d;
    logic is_key;
    d = '0;
    is_key = !r.func;
    case (st_mode)
      ocd_pkg::CODE_ARMED: begin
        if (is_key && r.key == ocd_pkg::KEY_START) begin
          if (!r.door) begin
            d.beep = 1'b1;
          end else if (entry_mins() > ocd_pkg::MAX_FIELD ||
                       entry_secs() > ocd_pkg::MAX_FIELD) begin
            d.bad = 1'b1;
            d.beep = 1'b1;
            clear_entry();
          end else begin
            st_min = ocd_pkg::TIME_W'(entry_mins());
            st_sec = ocd_pkg::TIME_W'(entry_secs());
            st_mode = ocd_pkg::CODE_RUN;
          end
        end else if (is_key && r.key == ocd_pkg::KEY_CANCEL) begin
          clear_entry();
        end
      end
      ocd_pkg::CODE_RUN: begin
        if (!r.door) begin
          st_mode = ocd_pkg::CODE_HOLD;
          d.beep = 1'b1;
        end else if (r.func) begin
          if (st_sec == 0) begin
            if (st_min != 0) begin
              st_sec = ocd_pkg::TIME_W'(ocd_pkg::MAX_FIELD);
              st_min = st_min - 1'b1;
            end
          end else begin
            st_sec = st_sec - 1'b1;
          end
          if (st_min == 0 && st_sec == 0) begin
            d.done = 1'b1;
            clear_entry();
          end
        end else if (r.key == ocd_pkg::KEY_START) begin
          st_mode = ocd_pkg::CODE_PAUSE;
        end
      end
      ocd_pkg::CODE_HOLD: begin
        if (is_key && r.key == ocd_pkg::KEY_START) begin
          if (r.door) st_mode = ocd_pkg::CODE_RUN;
          else d.beep = 1'b1;
        end
      end
      ocd_pkg::CODE_PAUSE: begin
        if (is_key && r.key == ocd_pkg::KEY_START) begin
          if (r.door) begin
            st_mode = ocd_pkg::CODE_RUN;
          end else begin
            st_mode = ocd_pkg::CODE_HOLD;
            d.beep = 1'b1;
          end
        end else if (is_key && r.key == ocd_pkg::KEY_CANCEL) begin
          clear_entry();
        end
      end
      default: begin
        if (st_mode != ocd_pkg::CODE_ENTRY) clear_entry();
        if (is_key) begin
          if (r.key >= ocd_pkg::KEY_ZERO && r.key <= ocd_pkg::KEY_NINE) begin
            for (int i = ocd_pkg::DIGITS - 1; i > 0; i--) st_dig[i] = st_dig[i-1];
            st_dig[0] = ocd_pkg::DIGIT_W'(r.key - ocd_pkg::KEY_ZERO);
          end
          st_presses = st_presses + 1'b1;
          if (st_presses >= ocd_pkg::DIGITS) begin
            st_presses = '0;
            if ((st_dig[0] | st_dig[1] | st_dig[2] | st_dig[3]) != 0) begin
              st_mode = ocd_pkg::CODE_ARMED;
            end else begin
              clear_entry();
            end
          end
        end
      end
    endcase
    d.mode = st_mode;
    if (st_mode == ocd_pkg::CODE_ENTRY || st_mode == ocd_pkg::CODE_ARMED) begin
      d.mins = ocd_pkg::TIME_W'(entry_mins());
      d.secs = ocd_pkg::TIME_W'(entry_secs());
    end else begin
      d.mins = st_min;
      d.secs = st_sec;
    end
    return d;
  endfunction

  task automatic push_req(logic func, logic [ocd_pkg::KEY_W-1:0] key, logic door);
    oven_req_t r;
    r.func = func;
    r.key = key;
    r.door = door;
    r.drain = mark_drain;
    mark_drain = 1'b0;
    req_pending.push_back(r);
  endtask

  task automatic push_key(logic [ocd_pkg::KEY_W-1:0] key, logic door);
    push_req(1'b0, key, door);
  endtask

  task automatic push_tick(logic door);
    push_req(1'b1, ocd_pkg::KEY_W'($urandom_range(0, 255)), door);
  endtask

  // A full cooking cycle: digit entry, start, then ticks with interruptions.
  task automatic queue_cook_cycle();
    logic [ocd_pkg::KEY_W-1:0] k[ocd_pkg::DIGITS];
    int m;
    int s;
    int n;
    int roll;
    bit valid_digits;
    if ($urandom_range(0, 9) == 0) begin
      for (int i = 0; i < ocd_pkg::DIGITS; i++) begin
        k[i] = ocd_pkg::KEY_ZERO + ocd_pkg::KEY_W'($urandom_range(0, 9));
      end
    end else begin
      m = ($urandom_range(0, 6) == 0) ? 1 : 0;
      s = $urandom_range(0, 25);
      k[0] = ocd_pkg::KEY_ZERO;
      k[1] = ocd_pkg::KEY_ZERO + ocd_pkg::KEY_W'(m);
      k[2] = ocd_pkg::KEY_ZERO + ocd_pkg::KEY_W'(s / 10);
      k[3] = ocd_pkg::KEY_ZERO + ocd_pkg::KEY_W'(s % 10);
    end
    if ($urandom_range(0, 9) == 0) begin
      k[$urandom_range(0, ocd_pkg::DIGITS - 1)] = ocd_pkg::KEY_W'($urandom_range(0, 255));
    end
    valid_digits = 1'b1;
    for (int i = 0; i < ocd_pkg::DIGITS; i++) begin
      push_key(k[i], $urandom_range(0, 7) != 0);
      if (k[i] < ocd_pkg::KEY_ZERO || k[i] > ocd_pkg::KEY_NINE) valid_digits = 1'b0;
    end
    if (valid_digits) begin
      n = int'(k[0] - ocd_pkg::KEY_ZERO) * 600 + int'(k[1] - ocd_pkg::KEY_ZERO) * 60 +
          int'(k[2] - ocd_pkg::KEY_ZERO) * 10 + int'(k[3] - ocd_pkg::KEY_ZERO);
      if (n > 130) n = 130;
    end else begin
      n = 5;
    end
    if ($urandom_range(0, 19) == 0) push_key(ocd_pkg::KEY_CANCEL, 1'b1);
    if ($urandom_range(0, 9) == 0) push_key(ocd_pkg::KEY_START, 1'b0);
    push_key(ocd_pkg::KEY_START, 1'b1);
    for (int j = 0; j < n + 2; j++) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        push_tick(1'b0);
        push_key(ocd_pkg::KEY_START, $urandom_range(0, 3) != 0);
        push_key(ocd_pkg::KEY_START, 1'b1);
      end else if (roll < 7) begin
        push_key(ocd_pkg::KEY_START, 1'b1);
        push_tick(1'($urandom_range(0, 1)));
        if ($urandom_range(0, 5) == 0) begin
          push_key(ocd_pkg::KEY_CANCEL, 1'($urandom_range(0, 1)));
          return;
        end
        push_key(ocd_pkg::KEY_START, 1'($urandom_range(0, 1)));
        push_key(ocd_pkg::KEY_START, 1'b1);
      end else if (roll < 9) begin
        push_key(ocd_pkg::KEY_CANCEL, 1'b1);
      end else if (roll == 9) begin
        push_key(ocd_pkg::KEY_W'($urandom_range(0, 255)), 1'b1);
      end else begin
        push_tick(1'b1);
      end
    end
  endtask

  task automatic queue_noise();
    logic [ocd_pkg::KEY_W-1:0] k;
    for (int i = $urandom_range(1, 4); i > 0; i--) begin
      case ($urandom_range(0, 5))
        0: k = ocd_pkg::KEY_START;
        1: k = ocd_pkg::KEY_CANCEL;
        2: k = ocd_pkg::KEY_ZERO + ocd_pkg::KEY_W'($urandom_range(0, 9));
        default: k = ocd_pkg::KEY_W'($urandom_range(0, 255));
      endcase
      push_req(1'($urandom_range(0, 1)), k, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic log_result_error(string why, oven_disp_t want, oven_disp_t got);
    n_err++;
    if (n_err <= 10) begin
      $display("Result %0d %s: expected mode %0d %0d:%0d beep %0b done %0b invalid %0b,",
               n_res, why, want.mode, want.mins, want.secs, want.beep, want.done, want.bad);
      $display("  got mode %0d %0d:%0d beep %0b done %0b invalid %0b",
               got.mode, got.mins, got.secs, got.beep, got.done, got.bad);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        disp_expected.push_back(oven_step(on_bus));
        n_req++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_tvalid <= 1'b0;
          in_gap--;
        end else if (req_pending.size() == 0 ||
                     (req_pending[0].drain && disp_expected.size() != 0)) begin
          in_tvalid <= 1'b0;
        end else begin
          on_bus = req_pending.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {7'd0, on_bus.door, on_bus.key};
          in_tuser <= on_bus.func;
          if ($urandom_range(0, 19) == 0) in_steady = !in_steady;
          in_gap = in_steady ? 0 : $urandom_range(0, 9);
        end
      end
    end
  end

  always @(posedge clk) begin
    oven_disp_t got;
    oven_disp_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.mode = out_tdata[2:0];
        got.mins = out_tdata[9:3];
        got.secs = out_tdata[16:10];
        got.beep = out_tdata[17];
        got.done = out_tdata[18];
        got.bad = out_tdata[19];
        n_res++;
        if (disp_expected.size() == 0) begin
          log_result_error("arrived unexpectedly", '0, got);
        end else begin
          want = disp_expected.pop_front();
          if (got != want) log_result_error("differs", want, got);
          n_done += want.done;
          n_bad += want.bad;
          n_beep += want.beep;
        end
        if ($urandom_range(0, 19) == 0) out_steady = !out_steady;
        out_stall = out_steady ? 0 : $urandom_range(0, 9);
      end
      if (out_stall > 0) begin
        out_tready <= 1'b0;
        out_stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Timed out after %0d cycles", cycle_cnt);
    $display("FAIL");
    $finish;
  end

  initial begin
    ref_init();
    // Tick in entry, then an all-zero entry that includes a non-digit key.
    push_tick(1'b0);
    push_key(8'hFF, 1'b1);
    push_key(ocd_pkg::KEY_ZERO, 1'b1);
    push_key(ocd_pkg::KEY_ZERO, 1'b0);
    push_key(ocd_pkg::KEY_ZERO, 1'b1);
    // 99:99 refused with the door open, then rejected as an invalid time.
    for (int i = 0; i < ocd_pkg::DIGITS; i++) push_key(ocd_pkg::KEY_NINE, 1'b1);
    push_key(ocd_pkg::KEY_START, 1'b0);
    push_key(ocd_pkg::KEY_START, 1'b1);
    // 01:00 borrows on the first tick, then door hold, pause and cancel.
    push_key(ocd_pkg::KEY_ZERO, 1'b1);
    push_key(ocd_pkg::KEY_ZERO + 8'd1, 1'b1);
    push_key(ocd_pkg::KEY_ZERO, 1'b1);
    push_key(ocd_pkg::KEY_ZERO, 1'b1);
    push_key(ocd_pkg::KEY_START, 1'b1);
    push_tick(1'b1);
    push_key(ocd_pkg::KEY_CANCEL, 1'b1);
    push_tick(1'b0);
    push_key(ocd_pkg::KEY_START, 1'b0);
    push_key(ocd_pkg::KEY_START, 1'b1);
    push_key(ocd_pkg::KEY_START, 1'b1);
    push_key(ocd_pkg::KEY_START, 1'b0);
    push_key(ocd_pkg::KEY_START, 1'b1);
    push_key(ocd_pkg::KEY_START, 1'b1);
    push_key(ocd_pkg::KEY_CANCEL, 1'b1);
    mark_drain = 1'b1;
    while (req_pending.size() < RANDOM_REQS + 26) begin
      if ($urandom_range(0, 9) == 0) mark_drain = 1'b1;
      if ($urandom_range(0, 99) < 75) queue_cook_cycle();
      else queue_noise();
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (req_pending.size() != 0 || in_tvalid) @(posedge clk);
    while (disp_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d requests, checked %0d results: %0d countdowns ran out,",
             n_req, n_res, n_done);
    $display("  %0d entries rejected as invalid, %0d beeps, %0d mismatches.",
             n_bad, n_beep, n_err);
    if (n_err == 0 && disp_expected.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
